/* sv/rebc_pkg.sv */
// Shared types and constants for the relative error bound checker.
// Holds the input and result item structs, the front-to-back job record
// and the point classification codes. No dependencies.
package rebc_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 63;

    localparam logic [CFG_IDX_W-1:0] REG_LEGACY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_ABS_TOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELATIVE_BOUND = 2'd2;

    localparam logic [62:0] DBL_INF_BITS = 63'h7FF0000000000000;

    typedef struct packed {
        logic [31:0] original_bits;
        logic [31:0] reconstructed_bits;
        logic        point_valid;
        logic        block_last;
    } in_item_t;

    typedef struct packed {
        logic        point_checked;
        logic        point_passed;
        logic [62:0] abs_error_bits;
        logic [62:0] rel_error_bits;
        logic        block_done;
        logic [6:0]  block_valid_count;
        logic [6:0]  block_violations;
        logic [62:0] block_max_abs_bits;
        logic [62:0] block_max_rel_bits;
        logic        block_passed;
    } out_item_t;

    // How the back part must finish a point.
    typedef enum logic [1:0] {
        CLS_SKIP   = 2'd0, // not valid: no evaluation
        CLS_FIXED  = 2'd1, // NaN or infinity involved: verdict known, errors zero
        CLS_ZERO   = 2'd2, // zero original
        CLS_FINITE = 2'd3  // finite: subtract and divide
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic        fixed_pass;
        logic        rec_zero;
        logic [63:0] ref_d;
        logic [63:0] val_d;
        logic        point_valid;
        logic        block_last;
    } job_t;

    // Widen a finite single to double bits (exact). Subnormals normalised.
    function automatic logic [63:0] sgl_to_dbl(input logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] m;
        logic [22:0] mm;
        logic [4:0]  lz;
        logic [10:0] de;
        logic        found;
        e = b[30:23];
        m = b[22:0];
        lz = 5'd0;
        found = 1'b0;
        mm = '0;
        de = '0;
        for (int i = 22; i >= 0; i--) begin
            if (!found && m[i]) begin
                found = 1'b1;
                lz = 5'(22 - i);
            end
        end
        if (e == 8'd0) begin
            if (m == 23'd0) begin
                de = 11'd0;
                mm = '0;
            end else begin
                mm = 23'(m << (lz + 5'd1));
                de = 11'(11'd896 - 11'(lz));
            end
        end else begin
            de = 11'(11'(e) + 11'd896);
            mm = m;
        end
        return {b[31], de, mm, 29'd0};
    endfunction

endpackage

/* sv/rebc_front.sv */
// Front part: takes input items, classifies each point and widens operands.
// Depends on rebc_pkg.
module rebc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  rebc_pkg::in_item_t item,
    output rebc_pkg::job_t     job
);
    import rebc_pkg::*;

    logic [7:0]  oexp;
    logic [7:0]  rexp;
    logic        onan;
    logic        oinf;
    logic        rnan;
    logic        rinf;

    assign oexp = item.original_bits[30:23];
    assign rexp = item.reconstructed_bits[30:23];
    assign onan = (oexp == 8'hFF) && (item.original_bits[22:0] != 23'd0);
    assign oinf = (oexp == 8'hFF) && (item.original_bits[22:0] == 23'd0);
    assign rnan = (rexp == 8'hFF) && (item.reconstructed_bits[22:0] != 23'd0);
    assign rinf = (rexp == 8'hFF) && (item.reconstructed_bits[22:0] == 23'd0);

    always_comb
    begin
        job.point_valid = item.point_valid;
        job.block_last = item.block_last;
        job.ref_d = sgl_to_dbl(item.original_bits);
        job.val_d = sgl_to_dbl(item.reconstructed_bits);
        job.rec_zero = (item.reconstructed_bits[30:0] == 31'd0);
        job.fixed_pass = 1'b0;
        if (!item.point_valid) begin
            job.cls = CLS_SKIP;
        end else if (onan) begin
            job.cls = CLS_FIXED;
            job.fixed_pass = rnan;
        end else if (oinf) begin
            job.cls = CLS_FIXED;
            job.fixed_pass = rinf && (item.original_bits[31] == item.reconstructed_bits[31]);
        end else if (rexp == 8'hFF) begin
            job.cls = CLS_FIXED;
        end else if (item.original_bits[30:0] == 31'd0) begin
            job.cls = CLS_ZERO;
        end else begin
            job.cls = CLS_FINITE;
        end
    end

    // clk and rst_n kept for a uniform part interface; front is combinational
    logic unused_ok;
    assign unused_ok = clk & rst_n;

endmodule

/* sv/rebc_queue.sv */
// Two-entry job queue between the front and back parts.
// Depends on rebc_pkg.
module rebc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rebc_pkg::job_t  wdata,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output rebc_pkg::job_t  rdata
);
    import rebc_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full) begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push && !full) begin
                wp_reg <= ~wp_reg;
            end
            if (pop && !empty) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= 2'(cnt_reg + 2'(push && !full) - 2'(pop && !empty));
        end
    end

endmodule

/* sv/rebc_div.sv */
// Iterative radix-2 divider for positive normal doubles, one quotient bit a cycle.
// Yields the round-to-nearest-even quotient bits. Depends on rebc_pkg.
module rebc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [62:0] num,
    input  logic [62:0] den,
    output logic        busy,
    output logic        done,
    output logic [62:0] quo
);
    import rebc_pkg::*;

    logic [54:0]       rem_reg;
    logic [52:0]       dsor_reg;
    logic [55:0]       q_reg;
    logic [5:0]        step_reg;
    logic signed [12:0] exp_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [62:0]       quo_reg;

    logic [54:0] trial;
    logic [55:0] q_shift;
    logic [54:0] rem_next;

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo = quo_reg;

    assign trial = rem_reg - {2'b0, dsor_reg};
    assign q_shift = {q_reg[54:0], ~trial[54]};
    assign rem_next = trial[54] ? {rem_reg[53:0], 1'b0} : {trial[53:0], 1'b0};

    // Normalise a quotient with 56 bits (first bit weight 2^0) and round.
    function automatic logic [62:0] finish(input logic [55:0] q, input logic sticky,
                                           input logic signed [12:0] e);
        logic [52:0]        mant;
        logic               g;
        logic               s;
        logic signed [12:0] ee;
        logic [53:0]        r;
        if (q[55]) begin
            mant = q[55:3];
            g = q[2];
            s = (q[1:0] != 2'd0) || sticky;
            ee = e;
        end else begin
            mant = q[54:2];
            g = q[1];
            s = q[0] || sticky;
            ee = 13'(e - 13'sd1);
        end
        r = {1'b0, mant} + 54'(g && (s || mant[0]));
        if (r[53]) begin
            r = r >> 1;
            ee = 13'(ee + 13'sd1);
        end
        if (ee >= 13'sd2047) begin
            return DBL_INF_BITS;
        end
        return {11'(ee), r[51:0]};
    endfunction

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg) begin
            rem_reg <= {2'b01, num[51:0], 1'b0} >> 1;
            dsor_reg <= {1'b1, den[51:0]};
            q_reg <= '0;
            exp_reg <= 13'(13'(num[62:52]) - 13'(den[62:52]) + 13'sd1023);
        end else if (busy_reg) begin
            q_reg <= q_shift;
            rem_reg <= rem_next;
        end
        if (busy_reg && step_reg == 6'd55) begin
            quo_reg <= finish(q_shift, rem_next != 55'd0, exp_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= 6'(step_reg + 6'd1);
                if (step_reg == 6'd55) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* sv/rebc_back.sv */
// Back part: double subtraction, relative error division, verdict and block statistics.
// Depends on rebc_pkg and rebc_div.
module rebc_back #(
    parameter int unsigned BLOCK_POINTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                legacy_mode,
    input  logic [62:0]         zero_abs_tolerance,
    input  logic [62:0]         relative_bound,
    input  logic                job_empty,
    input  rebc_pkg::job_t      job,
    output logic                job_pop,
    output logic                res_valid,
    output rebc_pkg::out_item_t res,
    input  logic                res_take
);
    import rebc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_NORM,
        ST_DIV,
        ST_WAIT,
        ST_DONE
    } state_t;

    localparam logic [6:0] TALLY_MAX = 7'(BLOCK_POINTS);

    state_t      state_reg;
    job_t        job_reg;
    logic [62:0] abs_reg;
    logic [62:0] rel_reg;
    logic        pass_reg;
    logic        res_valid_reg;
    out_item_t   res_reg;
    logic [6:0]  vt_reg;
    logic [6:0]  xt_reg;
    logic [62:0] mabs_reg;
    logic [62:0] mrel_reg;
    logic        allp_reg;

    // aligned significands, 3 guard bits plus sticky
    logic [56:0] big_reg;
    logic [56:0] sml_reg;
    logic        sub_reg;
    logic [10:0] bexp_reg;

    logic [10:0] e_a;
    logic [10:0] e_b;
    logic [52:0] m_a;
    logic [52:0] m_b;
    logic        a_ge_b;
    logic [10:0] ediff;
    logic [56:0] sml_pre;
    logic [56:0] sml_sh;
    logic        sml_st;

    logic [57:0] sum;
    logic [5:0]  lz;
    logic        lz_found;
    logic [62:0] abs_calc;

    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [62:0] div_quo;
    logic [62:0] rel_q;

    logic        rel_lt;
    logic        ae_le_tol;
    logic        aref_le_tol;
    logic        pass_fin;
    logic [62:0] aref;

    // Operands as magnitudes; the difference val - ref handles signs by add/sub.
    assign e_a = job_reg.val_d[62:52];
    assign e_b = job_reg.ref_d[62:52];
    assign m_a = {(e_a != 11'd0), job_reg.val_d[51:0]};
    assign m_b = {(e_b != 11'd0), job_reg.ref_d[51:0]};
    assign a_ge_b = (job_reg.val_d[62:0] >= job_reg.ref_d[62:0]);
    assign ediff = a_ge_b ? 11'(e_a - e_b) : 11'(e_b - e_a);
    assign sml_pre = a_ge_b ? {m_b, 4'd0} : {m_a, 4'd0};
    always_comb
    begin
        if (ediff >= 11'd57) begin
            sml_sh = '0;
            sml_st = (sml_pre != 57'd0);
        end else begin
            sml_sh = sml_pre >> ediff;
            sml_st = ((sml_pre & ((57'd1 << ediff) - 57'd1)) != 57'd0);
        end
    end

    // sum carries 1 overflow bit; bit 0 of big/sml is sticky
    assign sum = sub_reg ? ({1'b0, big_reg} - {1'b0, sml_reg})
                         : ({1'b0, big_reg} + {1'b0, sml_reg});

    always_comb
    begin
        lz = 6'd0;
        lz_found = 1'b0;
        for (int i = 56; i >= 0; i--) begin
            if (!lz_found && sum[i]) begin
                lz_found = 1'b1;
                lz = 6'(56 - i);
            end
        end
    end

    // Normalise and round the difference (exponents cannot underflow here:
    // single inputs sit far above the double subnormal range).
    always_comb
    begin
        logic [57:0]        nm;
        logic signed [12:0] ee;
        logic [52:0]        mant;
        logic               g;
        logic               s;
        logic [53:0]        r;
        nm = '0;
        ee = '0;
        mant = '0;
        g = 1'b0;
        s = 1'b0;
        r = '0;
        abs_calc = '0;
        if (sum == 58'd0) begin
            abs_calc = '0;
        end else if (sum[57]) begin
            mant = sum[57:5];
            g = sum[4];
            s = (sum[3:0] != 4'd0);
            ee = 13'(13'(bexp_reg) + 13'sd1);
        end else begin
            nm = sum << lz;
            mant = nm[56:4];
            g = nm[3];
            s = (nm[2:0] != 3'd0);
            ee = 13'(13'(bexp_reg) - 13'(lz));
        end
        if (sum != 58'd0) begin
            r = {1'b0, mant} + 54'(g && (s || mant[0]));
            if (r[53]) begin
                r = r >> 1;
                ee = 13'(ee + 13'sd1);
            end
            abs_calc = {11'(ee), r[51:0]};
        end
    end

    assign aref = job_reg.ref_d[62:0];
    assign div_start = (state_reg == ST_DIV);

    rebc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (abs_reg),
        .den   (aref),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // a zero difference gives a zero ratio; the divider assumes a normal numerator
    assign rel_q = (abs_reg == 63'd0) ? 63'd0 : div_quo;

    // Non-negative doubles order as their bits; a NaN register fails every test.
    assign rel_lt = (relative_bound <= DBL_INF_BITS) && (rel_q < relative_bound);
    assign ae_le_tol = (zero_abs_tolerance <= DBL_INF_BITS) && (abs_reg <= zero_abs_tolerance);
    assign aref_le_tol = (zero_abs_tolerance <= DBL_INF_BITS) && (aref <= zero_abs_tolerance);
    assign pass_fin = (legacy_mode && aref_le_tol) ? ae_le_tol : rel_lt;

    assign job_pop = (state_reg == ST_IDLE) && !job_empty;
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    always_ff @(posedge clk)
    begin
        if (job_pop) begin
            job_reg <= job;
        end
        if (state_reg == ST_ALIGN) begin
            big_reg <= a_ge_b ? {m_a, 4'd0} : {m_b, 4'd0};
            sml_reg <= {sml_sh[56:1], sml_sh[0] | sml_st};
            sub_reg <= (job_reg.val_d[63] == job_reg.ref_d[63]);
            bexp_reg <= (a_ge_b ? e_a : e_b);
        end
        if (state_reg == ST_NORM) begin
            abs_reg <= abs_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            res_valid_reg <= 1'b0;
            rel_reg <= '0;
            pass_reg <= 1'b0;
            res_reg <= '0;
            vt_reg <= '0;
            xt_reg <= '0;
            mabs_reg <= '0;
            mrel_reg <= '0;
            allp_reg <= 1'b1;
        end else begin
            // in ST_DONE the result flag is handled below
            if (res_valid_reg && res_take && state_reg != ST_DONE) begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_pop) begin
                        state_reg <= ST_ALIGN;
                    end
                end
                ST_ALIGN:
                begin
                    if (job_reg.cls == CLS_SKIP || job_reg.cls == CLS_FIXED) begin
                        pass_reg <= (job_reg.cls == CLS_FIXED) && job_reg.fixed_pass;
                        rel_reg <= '0;
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (job_reg.cls == CLS_ZERO) begin
                        rel_reg <= (abs_calc == 63'd0) ? 63'd0 : DBL_INF_BITS;
                        pass_reg <= legacy_mode
                            ? ((zero_abs_tolerance <= DBL_INF_BITS) &&
                               (abs_calc <= zero_abs_tolerance))
                            : job_reg.rec_zero;
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (div_done) begin
                        rel_reg <= rel_q;
                        pass_reg <= pass_fin;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!res_valid_reg || res_take) begin
                        logic        chk;
                        logic        pa;
                        logic [62:0] ae;
                        logic [62:0] re;
                        logic [6:0]  vt;
                        logic [6:0]  xt;
                        logic [62:0] ma;
                        logic [62:0] mr;
                        logic        ap;
                        chk = job_reg.point_valid;
                        pa = chk && pass_reg;
                        ae = (job_reg.cls == CLS_ZERO || job_reg.cls == CLS_FINITE)
                             ? abs_reg : 63'd0;
                        re = (job_reg.cls == CLS_ZERO || job_reg.cls == CLS_FINITE)
                             ? rel_reg : 63'd0;
                        vt = vt_reg;
                        xt = xt_reg;
                        ma = mabs_reg;
                        mr = mrel_reg;
                        ap = allp_reg;
                        if (chk) begin
                            if (vt < TALLY_MAX) begin
                                vt = 7'(vt + 7'd1);
                            end
                            if (ae > ma) begin
                                ma = ae;
                            end
                            if (re > mr) begin
                                mr = re;
                            end
                            if (!pa) begin
                                if (xt < TALLY_MAX) begin
                                    xt = 7'(xt + 7'd1);
                                end
                                ap = 1'b0;
                            end
                        end
                        res_reg <= '{point_checked: chk, point_passed: pa,
                                     abs_error_bits: ae, rel_error_bits: re,
                                     block_done: job_reg.block_last,
                                     block_valid_count: vt, block_violations: xt,
                                     block_max_abs_bits: ma, block_max_rel_bits: mr,
                                     block_passed: ap};
                        res_valid_reg <= 1'b1;
                        if (job_reg.block_last) begin
                            vt_reg <= '0;
                            xt_reg <= '0;
                            mabs_reg <= '0;
                            mrel_reg <= '0;
                            allp_reg <= 1'b1;
                        end else begin
                            vt_reg <= vt;
                            xt_reg <= xt;
                            mabs_reg <= ma;
                            mrel_reg <= mr;
                            allp_reg <= ap;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    logic unused_ok;
    assign unused_ok = div_busy;

endmodule

/* sv/relative_error_bound_checker_top.sv */
// Relative error bound checker: top level joining front, job queue and back part.
// Finite points pass through the radix-2 divider, one quotient bit a cycle;
// NaN, infinity, zero-original and skipped points bypass the divider.
// One point is worked at a time; the job queue holds two more, the result register one.
// Reset (rst_n, asynchronous, active low) clears registers, statistics and queues.
module relative_error_bound_checker_top #(
    parameter int unsigned BLOCK_POINTS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  rebc_pkg::in_item_t                   in_item,
    output logic                                 full,
    output logic                                 empty,
    input  logic                                 pop,
    output rebc_pkg::out_item_t                  out_item,
    input  logic                                 cfg_we,
    input  logic [rebc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rebc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rebc_pkg::*;

    logic        legacy_reg;
    logic [62:0] tol_reg;
    logic [62:0] bound_reg;

    job_t job_in;
    job_t job_out;
    logic q_empty;
    logic q_pop;
    logic res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            legacy_reg <= 1'b0;
            tol_reg <= '0;
            bound_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LEGACY_MODE:    legacy_reg <= cfg_data[0];
                REG_ZERO_ABS_TOL:   tol_reg <= cfg_data;
                REG_RELATIVE_BOUND: bound_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    rebc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (in_item),
        .job   (job_in)
    );

    rebc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job_in),
        .full  (full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (job_out)
    );

    rebc_back #(
        .BLOCK_POINTS (BLOCK_POINTS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .legacy_mode        (legacy_reg),
        .zero_abs_tolerance (tol_reg),
        .relative_bound     (bound_reg),
        .job_empty          (q_empty),
        .job                (job_out),
        .job_pop            (q_pop),
        .res_valid          (res_valid),
        .res                (out_item),
        .res_take           (pop)
    );

    assign empty = !res_valid;

`ifndef SYNTHESIS
    a_checked_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !out_item.point_checked |-> !out_item.point_passed)
        else $error("unchecked item marked passed");
    a_violations_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> out_item.block_violations <= out_item.block_valid_count)
        else $error("violations exceed valid count");
    a_pass_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && out_item.block_violations != 7'd0 |-> !out_item.block_passed)
        else $error("block passed with violations");
`endif

endmodule

/* tb/tb_relative_error_bound_checker_top.sv */
// Testbench for relative_error_bound_checker_top: directed and random items,
// predicted in IEEE double arithmetic and checked against each result item.
// Depends on rebc_pkg and the top level of the checker.
module tb_relative_error_bound_checker_top;
    import rebc_pkg::*;

    localparam int unsigned BLK_PTS = 64;
    localparam int unsigned IDLE_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam logic [63:0] MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    in_item_t              in_item;
    logic                  full;
    logic                  empty;
    logic                  pop;
    out_item_t             out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of registers and block statistics
    logic        cur_legacy;
    logic [62:0] cur_tol;
    logic [62:0] cur_bound;
    logic [6:0]  stat_valid;
    logic [6:0]  stat_viol;
    logic [63:0] stat_max_abs;
    logic [63:0] stat_max_rel;
    logic        stat_ok;

    out_item_t   verdict_q[$];
    int unsigned mismatches;
    int unsigned idle_cycles;
    int unsigned hold_left;
    bit          popped;

    relative_error_bound_checker_top #(.BLOCK_POINTS(BLK_PTS)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Widen single bits to double bits, normalising subnormals.
    function automatic logic [63:0] widen_single(input logic [31:0] s);
        logic [10:0] ex;
        logic [22:0] fr;
        int          sh;
        ex = 11'(s[30:23]);
        fr = s[22:0];
        if (s[30:0] == 31'd0)
            return {s[31], 63'd0};
        if (s[30:23] == 8'd0)
        begin
            sh = 0;
            while (!fr[22])
            begin
                fr = fr << 1;
                sh++;
            end
            fr = fr << 1;
            ex = 11'(896 - sh);
        end
        else
            ex = ex + 11'd896;
        return {s[31], ex, fr, 29'd0};
    endfunction

    function automatic bit point_rule(input logic [31:0] ob, input logic [31:0] rb,
                                      output logic [63:0] ae_b, output logic [63:0] re_b);
        real ae;
        real tol;
        real bnd;
        real aref;
        bit  o_nan;
        bit  r_nan;
        bit  o_inf;
        bit  r_inf;
        ae_b = '0;
        re_b = '0;
        tol = $bitstoreal({1'b0, cur_tol});
        bnd = $bitstoreal({1'b0, cur_bound});
        o_nan = (ob[30:23] == 8'hFF) && (ob[22:0] != 0);
        r_nan = (rb[30:23] == 8'hFF) && (rb[22:0] != 0);
        o_inf = (ob[30:23] == 8'hFF) && (ob[22:0] == 0);
        r_inf = (rb[30:23] == 8'hFF) && (rb[22:0] == 0);
        if (o_nan)
            return r_nan;
        if (o_inf)
            return r_inf && (ob[31] == rb[31]);
        if (r_nan || r_inf)
            return 1'b0;
        ae_b = $realtobits($bitstoreal(widen_single(rb)) - $bitstoreal(widen_single(ob)))
               & MAG_MASK;
        ae = $bitstoreal(ae_b);
        if (ob[30:0] == 31'd0)
        begin
            re_b = (ae_b == 0) ? 64'd0 : {1'b0, DBL_INF_BITS};
            if (cur_legacy)
                return ae <= tol;
            return rb[30:0] == 31'd0;
        end
        aref = $bitstoreal(widen_single(ob) & MAG_MASK);
        re_b = $realtobits(ae / aref) & MAG_MASK;
        if (cur_legacy && aref <= tol)
            return ae <= tol;
        return $bitstoreal(re_b) < bnd;
    endfunction

    function automatic out_item_t predict_verdict(input in_item_t it);
        out_item_t   r;
        logic [63:0] ae;
        logic [63:0] re;
        bit          ok;
        ae = '0;
        re = '0;
        ok = 1'b0;
        if (it.point_valid)
        begin
            ok = point_rule(it.original_bits, it.reconstructed_bits, ae, re);
            if (stat_valid < BLK_PTS)
                stat_valid++;
            if (ae > stat_max_abs)
                stat_max_abs = ae;
            if (re > stat_max_rel)
                stat_max_rel = re;
            if (!ok)
            begin
                if (stat_viol < BLK_PTS)
                    stat_viol++;
                stat_ok = 1'b0;
            end
        end
        r.point_checked = it.point_valid;
        r.point_passed = ok;
        r.abs_error_bits = ae[62:0];
        r.rel_error_bits = re[62:0];
        r.block_done = it.block_last;
        r.block_valid_count = stat_valid;
        r.block_violations = stat_viol;
        r.block_max_abs_bits = stat_max_abs[62:0];
        r.block_max_rel_bits = stat_max_rel[62:0];
        r.block_passed = stat_ok;
        if (it.block_last)
        begin
            stat_valid = '0;
            stat_viol = '0;
            stat_max_abs = '0;
            stat_max_rel = '0;
            stat_ok = 1'b1;
        end
        return r;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    task automatic send_item(input in_item_t it);
        int unsigned g;
        g = gap_len();
        repeat (g) @(negedge clk);
        push = 1'b1;
        in_item = it;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        verdict_q.push_back(predict_verdict(it));
        idle_cycles = 0;
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic send_pair(input logic [31:0] ob, input logic [31:0] rb,
                             input logic vld, input logic lst);
        in_item_t it;
        it.original_bits = ob;
        it.reconstructed_bits = rb;
        it.point_valid = vld;
        it.block_last = lst;
        send_item(it);
    endtask

    // Drain every outstanding item before touching the registers.
    task automatic wait_idle();
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [62:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_LEGACY_MODE:    cur_legacy = val[0];
            REG_ZERO_ABS_TOL:   cur_tol = val;
            REG_RELATIVE_BOUND: cur_bound = val;
            default: ;
        endcase
    endtask

    task automatic set_policy(input logic leg, input logic [62:0] tol, input logic [62:0] bnd);
        wait_idle();
        write_reg(REG_LEGACY_MODE, {62'd0, leg});
        write_reg(REG_ZERO_ABS_TOL, tol);
        write_reg(REG_RELATIVE_BOUND, bnd);
    endtask

    function automatic logic [31:0] rand_single();
        int unsigned k;
        logic [31:0] v;
        v = $urandom;
        k = $urandom_range(0, 19);
        case (k)
            0: v[30:0] = '0;
            1: v[30:0] = 31'h7F80_0000;
            2: v[30:23] = 8'hFF;
            3: v[30:23] = 8'h00;
            4: v[30:0] = 31'h7F7F_FFFF;
            5: v[30:0] = 31'h0000_0001;
            6: ;
            default: v[30:23] = 8'(int'($urandom_range(100, 150)));
        endcase
        if (k == 2 && v[22:0] == 0)
            v[0] = 1'b1;
        return v;
    endfunction

    function automatic logic [31:0] rand_recon(input logic [31:0] ob);
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 2)
            return ob;
        if (k < 7)
            return ob + 32'($urandom_range(0, 4000)) - 32'd2000;
        return rand_single();
    endfunction

    task automatic test_special_points();
        send_pair(32'h7FC0_0000, 32'hFFA0_0001, 1'b1, 1'b0); // NaN against NaN
        send_pair(32'h7F80_0001, 32'h3F80_0000, 1'b1, 1'b0); // NaN against finite
        send_pair(32'h7F80_0000, 32'h7F80_0000, 1'b1, 1'b0);
        send_pair(32'hFF80_0000, 32'h7F80_0000, 1'b1, 1'b0); // wrong infinity sign
        send_pair(32'hFF80_0000, 32'h7FC0_0000, 1'b1, 1'b0);
        send_pair(32'h3F80_0000, 32'h7F80_0000, 1'b1, 1'b0);
        send_pair(32'h3F80_0000, 32'hFFC0_0000, 1'b1, 1'b0);
        send_pair(32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0); // signed zeros
        send_pair(32'h8000_0000, 32'h0000_0001, 1'b1, 1'b0);
        send_pair(32'h0000_0000, 32'h3F80_0000, 1'b1, 1'b0);
        send_pair(32'h3F80_0000, 32'h3F80_0000, 1'b1, 1'b0);
        send_pair(32'h3F80_0000, 32'h3F80_0010, 1'b1, 1'b0);
        send_pair(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b1, 1'b0);
        send_pair(32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0);
        send_pair(32'h807F_FFFF, 32'h0000_0003, 1'b1, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0); // skipped point
        send_pair(32'hC2C8_0000, 32'hC2C8_0001, 1'b1, 1'b1);
        send_pair(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1); // empty block
    endtask

    task automatic test_tally_saturation();
        int i;
        for (i = 0; i < 70; i++)
            send_pair(32'h4000_0000, 32'h4080_0000, 1'b1, i == 69);
    endtask

    task automatic test_random_blocks(input int unsigned n);
        int unsigned left;
        int unsigned pos;
        logic [31:0] ob;
        left = 0;
        pos = 0;
        repeat (n)
        begin
            if (left == 0)
                left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                   : $urandom_range(1, 20);
            ob = rand_single();
            left--;
            send_pair(ob, rand_recon(ob), $urandom_range(0, 9) != 0, left == 0);
        end
    endtask

    task automatic test_backpressure();
        hold_left = 2500;
        test_random_blocks(30);
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_legacy = 1'b0;
        cur_tol = '0;
        cur_bound = '0;
        stat_valid = '0;
        stat_viol = '0;
        stat_max_abs = '0;
        stat_max_rel = '0;
        stat_ok = 1'b1;
        mismatches = 0;
        idle_cycles = 0;
        hold_left = 0;
        popped = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_special_points();
        set_policy(1'b1, 63'($realtobits(1.0e-3)), 63'($realtobits(1.0e-4)));
        test_special_points();
        test_tally_saturation();
        set_policy(1'b0, 63'($realtobits(1.0e-6)), 63'($realtobits(2.0e-5)));
        test_random_blocks(400);
        test_backpressure();
        set_policy(1'b1, 63'($realtobits(1.0e-30)), 63'($realtobits(1.0e-7)));
        test_random_blocks(400);
        set_policy(1'b1, {1'b0, DBL_INF_BITS[61:0]} | DBL_INF_BITS, 63'd0);
        test_random_blocks(300);
        set_policy(1'b0, 63'd0, DBL_INF_BITS);
        test_random_blocks(300);
        // NaN patterns: every comparison fails
        set_policy(1'b1, '1, 63'h7FF8_0000_0000_0000);
        test_special_points();
        test_random_blocks(300);

        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // receiver: random gaps, plus a long hold when asked
    initial
    begin
        pop = 1'b0;
        forever
        begin
            int unsigned g;
            g = 0;
            @(negedge clk);
            while (hold_left > 0)
            begin
                pop = 1'b0;
                hold_left--;
                @(negedge clk);
            end
            if (popped)
            begin
                popped = 1'b0;
                g = gap_len();
            end
            if (g > 0)
            begin
                pop = 1'b0;
                repeat (g - 1) @(negedge clk);
            end
            else
                pop = rst_n;
        end
    end

    task automatic check_field(input string nm, input logic [62:0] e, input logic [62:0] g);
        if (e !== g)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h got %h", nm, e, g);
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && pop && !empty)
        begin
            popped = 1'b1;
            idle_cycles = 0;
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", out_item);
            end
            else
            begin
                e = verdict_q.pop_front();
                check_field("point_checked", 63'(e.point_checked), 63'(out_item.point_checked));
                check_field("point_passed", 63'(e.point_passed), 63'(out_item.point_passed));
                check_field("abs_error_bits", e.abs_error_bits, out_item.abs_error_bits);
                check_field("rel_error_bits", e.rel_error_bits, out_item.rel_error_bits);
                check_field("block_done", 63'(e.block_done), 63'(out_item.block_done));
                check_field("block_valid_count", 63'(e.block_valid_count),
                            63'(out_item.block_valid_count));
                check_field("block_violations", 63'(e.block_violations),
                            63'(out_item.block_violations));
                check_field("block_max_abs_bits", e.block_max_abs_bits,
                            out_item.block_max_abs_bits);
                check_field("block_max_rel_bits", e.block_max_rel_bits,
                            out_item.block_max_rel_bits);
                check_field("block_passed", 63'(e.block_passed), 63'(out_item.block_passed));
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(negedge clk)
    begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
